### rtl/rpy_pkg.sv
// Shared constants, types and helper functions for the rotation-to-RPY block.
package rpy_pkg;

  localparam int DW                = 44;  // CORDIC x/y datapath width
  localparam int ZW                = 36;  // angle accumulator width, 2^-32 rad
  localparam int GUARD             = 8;   // guard bits below the Q1.30 operands
  localparam int ELEM_W            = 32;
  localparam int ANG_W             = 31;
  localparam int SY_W              = 34;
  localparam int LIMIT_W           = 31;
  localparam int CORDIC_STAGES_DEF = 32;
  localparam int ADDR_W            = 3;
  localparam int DATA_W            = 32;

  localparam logic [15:0]          INVK_HI        = 16'h9B74;
  localparam logic [15:0]          INVK_LO        = 16'hEDA8;
  localparam logic [LIMIT_W-1:0]   SINGULAR_RESET = 31'd1074;
  localparam logic signed [ZW-4:0] ANG_LIMIT      = 33'sd843314857;

  // Register indexes
  localparam logic REG_SINGULAR = 1'b0;

  typedef logic signed [ANG_W-1:0] angle_t;

  // atan(2^-i) at 2^-32 rad, rounded to nearest
  function automatic longint atan_entry(input int i);
    longint v;
    v = 0;
    case (i)
      0:  v = 64'd3373259426;
      1:  v = 64'd1991351318;
      2:  v = 64'd1052175346;
      3:  v = 64'd534100635;
      4:  v = 64'd268086748;
      5:  v = 64'd134174063;
      6:  v = 64'd67103403;
      7:  v = 64'd33553749;
      8:  v = 64'd16777131;
      9:  v = 64'd8388597;
      10: v = 64'd4194303;
      default: begin
        if (i <= 32) v = 64'sd1 <<< (32 - i);
        else v = 0;
      end
    endcase
    return v;
  endfunction

  // Round the accumulator to Q3.28 and clamp to +/-pi
  function automatic angle_t angle_round(input logic signed [ZW-1:0] z);
    logic signed [ZW:0]   t;
    logic signed [ZW-4:0] r;
    t = {z[ZW-1], z} + (ZW+1)'(8);
    r = (ZW-3)'(t >>> 4);
    if (r > ANG_LIMIT) r = ANG_LIMIT;
    else if (r < -ANG_LIMIT) r = -ANG_LIMIT;
    return r[ANG_W-1:0];
  endfunction

  // Q1.30 element (or its 33-bit negation) scaled up by the guard bits
  function automatic logic signed [DW-1:0] widen(input logic signed [ELEM_W:0] v);
    return {{(DW-ELEM_W-1-GUARD){v[ELEM_W]}}, v, {GUARD{1'b0}}};
  endfunction

endpackage

### rtl/rpy_in_if.sv
// Matrix input channel: seven Q1.30 elements.
interface rpy_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r00;
  logic signed [31:0] r10;
  logic signed [31:0] r20;
  logic signed [31:0] r21;
  logic signed [31:0] r22;
  logic signed [31:0] r11;
  logic signed [31:0] r12;

  modport source(output valid, r00, r10, r20, r21, r22, r11, r12, input ready);
  modport sink(input valid, r00, r10, r20, r21, r22, r11, r12, output ready);
endinterface

### rtl/rpy_out_if.sv
// Angle output channel: roll, pitch, yaw in Q3.28 radians plus lock flag.
interface rpy_out_if;
  logic               valid;
  logic               ready;
  logic signed [30:0] roll_angle;
  logic signed [30:0] pitch_angle;
  logic signed [30:0] yaw_angle;
  logic               gimbal_lock;

  modport source(output valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
                 input ready);
  modport sink(input valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
               output ready);
endinterface

### rtl/rpy_cordic.sv
// Unrolled vectoring CORDIC pipeline: quadrant fold plus one register per micro-rotation.
module rpy_cordic #(
  parameter int STAGES = rpy_pkg::CORDIC_STAGES_DEF,
  parameter int SBW    = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [rpy_pkg::DW-1:0]   x_in,
  input  logic signed [rpy_pkg::DW-1:0]   y_in,
  input  logic [SBW-1:0]                  side_in,
  output logic                            out_valid,
  output logic signed [rpy_pkg::DW-1:0]   x_out,
  output logic signed [rpy_pkg::ZW-1:0]   z_out,
  output logic [SBW-1:0]                  side_out
);
  import rpy_pkg::*;

  localparam logic signed [ZW-1:0] Z_FOLD = ZW'(2 * atan_entry(0));

  logic                 vld [STAGES+1];
  logic signed [DW-1:0] xs  [STAGES+1];
  logic signed [DW-1:0] ys  [STAGES+1];
  logic signed [ZW-1:0] zs  [STAGES+1];
  logic [SBW-1:0]       sd  [STAGES+1];

  // Fold the left half-plane into the right one
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (en) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side_in;
      if (x_in[DW-1]) begin
        if (!y_in[DW-1]) begin
          xs[0] <= y_in;
          ys[0] <= -x_in;
          zs[0] <= Z_FOLD;
        end else begin
          xs[0] <= -y_in;
          ys[0] <= x_in;
          zs[0] <= -Z_FOLD;
        end
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ANG = ZW'(atan_entry(i));

    always_ff @(posedge clk) begin
      if (rst) vld[i+1] <= 1'b0;
      else if (en) vld[i+1] <= vld[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        if (!ys[i][DW-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ANG;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ANG;
        end
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign x_out     = xs[STAGES];
  assign z_out     = zs[STAGES];
  assign side_out  = sd[STAGES];

endmodule

### rtl/rotation_matrix_to_euler_rpy.sv
// Top level: rotation matrix to roll/pitch/yaw, fully pipelined CORDIC datapath.
//
//   channel | dir | payload                                          | transfer
//   --------+-----+--------------------------------------------------+----------------
//   mat     | in  | r00 r10 r20 r21 r22 r11 r12, Q1.30               | valid & ready
//   ang     | out | roll/pitch/yaw_angle Q3.28, gimbal_lock          | valid & ready
//   apb     | in  | singular_limit at byte address 0                 | psel & penable
//
// One transaction per cycle unless the output stalls; the path runs through two
// chained CORDIC pipelines (magnitude/yaw/roll, then pitch on sy), each fold +
// STAGES registers, the m1/m2 1/K multiply registers and the output register.
// A full output register that is not taken freezes the whole pipeline in place.
// Synchronous reset clears the valid bits and loads the default limit.
module rotation_matrix_to_euler_rpy #(
  parameter int CORDIC_STAGES = rpy_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  rpy_in_if.sink                       mat,
  rpy_out_if.source                    ang,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpy_pkg::ADDR_W-1:0]   paddr,
  input  logic [rpy_pkg::DATA_W-1:0]   pwdata,
  output logic [rpy_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import rpy_pkg::*;

  localparam int XF_W = DW - 1;
  localparam int PW   = XF_W + 16;
  localparam int SW   = PW + 1;
  localparam int SBA  = ELEM_W + 1;
  localparam int SBP  = 2 * ANG_W + 2;

  logic en;
  logic [LIMIT_W-1:0] singular_limit;
  logic reg_idx;

  // Configuration
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) singular_limit <= SINGULAR_RESET;
    else if (psel && penable && pwrite && reg_idx == REG_SINGULAR)
      singular_limit <= pwdata[LIMIT_W-1:0];
  end

  always_comb begin
    unique case (reg_idx)
      REG_SINGULAR: prdata = {{(DATA_W-LIMIT_W){1'b0}}, singular_limit};
      default:      prdata = '0;
    endcase
  end

  assign en        = !ang.valid || ang.ready;
  assign mat.ready = en;

  // First pass: |(r00,r10)| and yaw, normal roll, gimbal-lock roll
  logic                 a_v;
  logic signed [DW-1:0] a_x;
  logic signed [ZW-1:0] a_z, b_z, c_z;
  logic [SBA-1:0]       a_sd;
  logic                 b_sd, c_sd;

  rpy_cordic #(.STAGES(CORDIC_STAGES), .SBW(SBA)) u_cord_a (
    .clk(clk), .rst(rst), .en(en), .in_valid(mat.valid),
    .x_in(widen({mat.r00[31], mat.r00})), .y_in(widen({mat.r10[31], mat.r10})),
    .side_in({mat.r20, (mat.r00 == '0 && mat.r10 == '0)}),
    .out_valid(a_v), .x_out(a_x), .z_out(a_z), .side_out(a_sd)
  );

  rpy_cordic #(.STAGES(CORDIC_STAGES), .SBW(1)) u_cord_b (
    .clk(clk), .rst(rst), .en(en), .in_valid(mat.valid),
    .x_in(widen({mat.r22[31], mat.r22})), .y_in(widen({mat.r21[31], mat.r21})),
    .side_in(mat.r22 == '0 && mat.r21 == '0),
    .out_valid(), .x_out(), .z_out(b_z), .side_out(b_sd)
  );

  rpy_cordic #(.STAGES(CORDIC_STAGES), .SBW(1)) u_cord_c (
    .clk(clk), .rst(rst), .en(en), .in_valid(mat.valid),
    .x_in(widen({mat.r11[31], mat.r11})), .y_in(widen(-{mat.r12[31], mat.r12})),
    .side_in(mat.r11 == '0 && mat.r12 == '0),
    .out_valid(), .x_out(), .z_out(c_z), .side_out(c_sd)
  );

  // 1/K scaling, partial products
  logic [XF_W-1:0]          xf;
  logic                     m1_v;
  logic [PW-1:0]            m1_hi, m1_lo;
  logic signed [ELEM_W-1:0] m1_r20;
  angle_t                   m1_yaw, m1_roll_b, m1_roll_c;

  assign xf = a_x[DW-1] ? '0 : a_x[XF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) m1_v <= 1'b0;
    else if (en) m1_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_hi     <= {16'b0, xf} * {{XF_W{1'b0}}, INVK_HI};
      m1_lo     <= {16'b0, xf} * {{XF_W{1'b0}}, INVK_LO};
      m1_r20    <= a_sd[SBA-1:1];
      m1_yaw    <= a_sd[0] ? '0 : angle_round(a_z);
      m1_roll_b <= b_sd ? '0 : angle_round(b_z);
      m1_roll_c <= c_sd ? '0 : angle_round(c_z);
    end
  end

  // sy, lock decision and selection
  logic [SW-1:0]             sum_r;
  logic [SY_W-1:0]           sy;
  logic                      lock;
  logic                      m2_v, m2_lock, m2_zero;
  logic [SY_W-1:0]           m2_sy;
  logic signed [ELEM_W:0]    m2_nr20;
  angle_t                    m2_roll, m2_yaw;

  assign sum_r = {1'b0, m1_hi} + {17'b0, m1_lo[PW-1:16]} + SW'(1 << (15 + GUARD));
  assign sy    = sum_r[SY_W+16+GUARD-1:16+GUARD];
  assign lock  = sy < {{(SY_W-LIMIT_W){1'b0}}, singular_limit};

  always_ff @(posedge clk) begin
    if (rst) m2_v <= 1'b0;
    else if (en) m2_v <= m1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_sy   <= sy;
      m2_nr20 <= -{m1_r20[ELEM_W-1], m1_r20};
      m2_zero <= (sy == '0) && (m1_r20 == '0);
      m2_lock <= lock;
      m2_roll <= lock ? m1_roll_c : m1_roll_b;
      m2_yaw  <= lock ? '0 : m1_yaw;
    end
  end

  // Second pass: pitch = atan2(-r20, sy)
  logic                 p_v;
  logic signed [ZW-1:0] p_z;
  logic [SBP-1:0]       p_sd;

  rpy_cordic #(.STAGES(CORDIC_STAGES), .SBW(SBP)) u_cord_p (
    .clk(clk), .rst(rst), .en(en), .in_valid(m2_v),
    .x_in({{(DW-SY_W-GUARD){1'b0}}, m2_sy, {GUARD{1'b0}}}), .y_in(widen(m2_nr20)),
    .side_in({m2_roll, m2_yaw, m2_lock, m2_zero}),
    .out_valid(p_v), .x_out(), .z_out(p_z), .side_out(p_sd)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) ang.valid <= 1'b0;
    else if (en) ang.valid <= p_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang.roll_angle  <= p_sd[SBP-1:ANG_W+2];
      ang.yaw_angle   <= p_sd[ANG_W+1:2];
      ang.gimbal_lock <= p_sd[1];
      ang.pitch_angle <= p_sd[0] ? '0 : angle_round(p_z);
    end
  end

endmodule
